FILE: design/gjts_pkg.sv
// shared types and constants for the gantry home, jog and teach sequencer
package gjts_pkg;

   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 72;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned OUT_POS_W  = 16;
   localparam int unsigned STEP_COUNTS = 4;
   localparam logic [9:0]  PRESS_TIMER_MAX = 10'd1023;
   localparam logic [7:0]  ESTOP_TIMER_MAX = 8'd255;

   // register indexes on the csr port (word addresses)
   localparam logic [2:0] REG_STEP_PERIOD    = 3'd0;
   localparam logic [2:0] REG_X_CENTRE_LOW   = 3'd1;
   localparam logic [2:0] REG_X_CENTRE_HIGH  = 3'd2;
   localparam logic [2:0] REG_Y_CENTRE_LOW   = 3'd3;
   localparam logic [2:0] REG_Y_CENTRE_HIGH  = 3'd4;
   localparam logic [2:0] REG_PRESS_DEBOUNCE = 3'd5;
   localparam logic [2:0] REG_ESTOP_DEBOUNCE = 3'd6;

   typedef enum logic [1:0] {
      DIR_IDLE = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_REV  = 2'd2
   } dir_type;

   typedef enum logic [7:0] {
      PH_ESTOP  = 8'b0000_0001,
      PH_HOME_X = 8'b0000_0010,
      PH_HOME_Y = 8'b0000_0100,
      PH_HOME_Z = 8'b0000_1000,
      PH_JOG    = 8'b0001_0000,
      PH_PICK   = 8'b0010_0000,
      PH_DROP   = 8'b0100_0000,
      PH_DONE   = 8'b1000_0000
   } phase_type;

   // per-axis command from the sequencer to a step engine
   typedef struct packed {
      logic    clear;
      logic    stop;
      logic    zero;
      logic    start;
      dir_type dir;
   } axis_cmd_type;

   function automatic logic [2:0] phase_code(input phase_type ph);
      logic [2:0] c;
      case (ph)
         PH_ESTOP:  c = 3'd0;
         PH_HOME_X: c = 3'd1;
         PH_HOME_Y: c = 3'd2;
         PH_HOME_Z: c = 3'd3;
         PH_JOG:    c = 3'd4;
         PH_PICK:   c = 3'd5;
         PH_DROP:   c = 3'd6;
         PH_DONE:   c = 3'd7;
         default:   c = 3'd0;
      endcase
      return c;
   endfunction

endpackage

FILE: design/gjts_axis.sv
// one stepper axis: coil phase sequencer and saturating position counter
module gjts_axis #(
   parameter int PHASES    = 4,
   parameter int POS_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  gjts_pkg::axis_cmd_type        cmd,
   input  logic [7:0]                    step_period,
   output gjts_pkg::dir_type             busy,
   output logic signed [POS_WIDTH-1:0]   position,
   output logic signed [POS_WIDTH-1:0]   position_next,
   output logic [3:0]                    coils
);
   import gjts_pkg::*;

   localparam int IW = $clog2(PHASES) + 1;
   localparam logic signed [POS_WIDTH:0] POS_MAX = (POS_WIDTH+1)'((64'sd1 <<< (POS_WIDTH-1)) - 1);
   localparam logic signed [POS_WIDTH:0] POS_MIN = -POS_MAX - 1;

   dir_type                busy_ff, busy_in, busy_mid;
   logic [IW-1:0]          idx_ff, idx_in, idx_mid, idx_inc;
   logic [7:0]             tmr_ff, tmr_in, tmr_mid, tmr_inc;
   logic signed [POS_WIDTH-1:0] pos_ff, pos_in, pos_mid;
   logic signed [POS_WIDTH:0]   pos_sum;

   always_comb begin
      // sequencer decisions first
      busy_mid = busy_ff;
      idx_mid  = idx_ff;
      tmr_mid  = tmr_ff;
      pos_mid  = pos_ff;
      if (cmd.clear || cmd.stop) begin
         busy_mid = DIR_IDLE;
         idx_mid  = '0;
         tmr_mid  = '0;
      end else if (cmd.start && busy_ff == DIR_IDLE) begin
         busy_mid = cmd.dir;
         idx_mid  = '0;
         tmr_mid  = '0;
      end
      if (cmd.clear || cmd.zero) begin
         pos_mid = '0;
      end

      // then the step engine
      busy_in = busy_mid;
      idx_in  = idx_mid;
      tmr_in  = tmr_mid;
      pos_in  = pos_mid;
      coils   = 4'b0000;
      idx_inc = idx_mid + 1'b1;
      tmr_inc = tmr_mid + 8'd1;
      pos_sum = (busy_mid == DIR_FWD) ? (POS_WIDTH+1)'(pos_mid) + (POS_WIDTH+1)'(STEP_COUNTS)
                                      : (POS_WIDTH+1)'(pos_mid) - (POS_WIDTH+1)'(STEP_COUNTS);
      if (busy_mid != DIR_IDLE) begin
         coils  = (busy_mid == DIR_FWD) ? (4'b0001 << idx_mid[1:0]) : (4'b1000 >> idx_mid[1:0]);
         tmr_in = tmr_inc;
         if (tmr_inc >= step_period) begin
            tmr_in = '0;
            idx_in = idx_inc;
            if (idx_inc >= IW'(PHASES)) begin
               busy_in = DIR_IDLE;
               idx_in  = '0;
               if (pos_sum > POS_MAX)      pos_in = POS_MAX[POS_WIDTH-1:0];
               else if (pos_sum < POS_MIN) pos_in = POS_MIN[POS_WIDTH-1:0];
               else                        pos_in = pos_sum[POS_WIDTH-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= DIR_IDLE;
         idx_ff  <= '0;
         tmr_ff  <= '0;
         pos_ff  <= '0;
      end else if (enable) begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         tmr_ff  <= tmr_in;
         pos_ff  <= pos_in;
      end
   end

   assign busy          = busy_ff;
   assign position      = pos_ff;
   assign position_next = pos_in;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff < IW'(PHASES)) else $error("coil index past last phase");
   a_idle_idx: assert property (@(posedge clock) disable iff (reset)
      busy_ff == DIR_IDLE |-> idx_ff == '0 && tmr_ff == '0) else $error("idle axis not parked");
   a_coils: assert property (@(posedge clock) disable iff (reset)
      $onehot0(coils)) else $error("coil pattern not one-hot");

endmodule

FILE: design/gantry_home_jog_teach_sequencer.sv
// top level: input register, run sequencer, three axis engines, result register
//
// One item is one millisecond tick of sampled joystick, buttons and switches.
// It is captured in an input register and turned into its result; results
// sit in an output register, so a new item is taken every cycle while the
// result side keeps up. The result holds the coil patterns shown for the tick,
// the run phase, the teach stage and the axis positions after the tick.
// Configuration is to be written over the csr port only while no item is in
// flight; the block itself does not enforce this.
module gantry_home_jog_teach_sequencer #(
   parameter int PHASES    = 4,
   parameter int POS_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // joy_x, joy_y, z_plus, z_minus, endstop_level, enter_level, estop_level
   input  logic [gjts_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // coils_x, coils_y, coils_z, phase_of_run, teach_stage,
   // position_x, position_y, position_z
   output logic [gjts_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [gjts_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import gjts_pkg::*;

   // configuration
   logic [7:0]  step_period_ff;
   logic [15:0] xcl_ff, xch_ff, ycl_ff, ych_ff;
   logic [9:0]  pdb_ff;
   logic [7:0]  edb_ff;
   logic        csr_wr;

   // pipeline
   logic        s1_valid_ff;
   logic [36:0] s1_data_ff;
   logic        adv;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic        rsp_valid_ff;

   // sequencer state
   phase_type   ph_ff, ph_in;
   logic [1:0]  mv_axis_ff, mv_axis_in;
   logic [15:0] rem_ff, rem_in;
   logic [1:0]  teach_ff, teach_in;
   logic [9:0]  pt_ff, pt_in, pt_inc;
   logic [7:0]  et_ff, et_in, et_inc;
   logic [2:0]  lv_ff, lv_in;
   logic signed [POS_WIDTH-1:0] pick_ff [3];
   logic signed [POS_WIDTH-1:0] pick_in [3];
   logic signed [POS_WIDTH-1:0] drop_ff [3];
   logic signed [POS_WIDTH-1:0] drop_in [3];

   // axis interface
   axis_cmd_type cmd [3];
   dir_type      busy [3];
   logic signed [POS_WIDTH-1:0] pos [3];
   logic signed [POS_WIDTH-1:0] pos_nx [3];
   logic [3:0]   coils [3];

   // input fields
   logic [15:0] jx, jy;
   logic        zp, zm, endl, entl, estl;
   logic        end_fall, est_fall, est_rise, all_idle;

   // move arithmetic
   logic [1:0]  cur_a, ld_a, home_a;
   logic        ld_drop, in_move;
   logic signed [POS_WIDTH:0] cur_d, ld_d;
   logic [15:0] rem_load;

   function automatic logic [15:0] steps_of(input logic signed [POS_WIDTH:0] d);
      logic [POS_WIDTH:0] mag;
      logic [33:0]        q;
      mag = d[POS_WIDTH] ? (POS_WIDTH+1)'(0) - d : d;
      q   = 34'(mag >> 2);
      return (q > 34'd65535) ? 16'hFFFF : q[15:0];
   endfunction

   // csr port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[4:2])
         REG_STEP_PERIOD:    csr_prdata = {24'd0, step_period_ff};
         REG_X_CENTRE_LOW:   csr_prdata = {16'd0, xcl_ff};
         REG_X_CENTRE_HIGH:  csr_prdata = {16'd0, xch_ff};
         REG_Y_CENTRE_LOW:   csr_prdata = {16'd0, ycl_ff};
         REG_Y_CENTRE_HIGH:  csr_prdata = {16'd0, ych_ff};
         REG_PRESS_DEBOUNCE: csr_prdata = {22'd0, pdb_ff};
         REG_ESTOP_DEBOUNCE: csr_prdata = {24'd0, edb_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_period_ff <= 8'd3;
         xcl_ff         <= 16'd31000;
         xch_ff         <= 16'd33500;
         ycl_ff         <= 16'd31000;
         ych_ff         <= 16'd34500;
         pdb_ff         <= 10'd250;
         edb_ff         <= 8'd15;
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            REG_STEP_PERIOD:    step_period_ff <= csr_pwdata[7:0];
            REG_X_CENTRE_LOW:   xcl_ff         <= csr_pwdata[15:0];
            REG_X_CENTRE_HIGH:  xch_ff         <= csr_pwdata[15:0];
            REG_Y_CENTRE_LOW:   ycl_ff         <= csr_pwdata[15:0];
            REG_Y_CENTRE_HIGH:  ych_ff         <= csr_pwdata[15:0];
            REG_PRESS_DEBOUNCE: pdb_ff         <= csr_pwdata[9:0];
            REG_ESTOP_DEBOUNCE: edb_ff         <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign adv        = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) s1_valid_ff <= req_tvalid;
         if (adv) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) s1_data_ff <= req_tdata[36:0];
      if (adv) rsp_data_ff <= rsp_data_in;
   end

   assign jx   = s1_data_ff[15:0];
   assign jy   = s1_data_ff[31:16];
   assign zp   = s1_data_ff[32];
   assign zm   = s1_data_ff[33];
   assign endl = s1_data_ff[34];
   assign entl = s1_data_ff[35];
   assign estl = s1_data_ff[36];

   assign end_fall = lv_ff[0] && !endl;
   assign est_fall = lv_ff[2] && !estl;
   assign est_rise = !lv_ff[2] && estl;
   assign all_idle = busy[0] == DIR_IDLE && busy[1] == DIR_IDLE && busy[2] == DIR_IDLE;
   assign pt_inc   = (pt_ff < PRESS_TIMER_MAX) ? pt_ff + 10'd1 : pt_ff;
   assign et_inc   = (et_ff < ESTOP_TIMER_MAX) ? et_ff + 8'd1 : et_ff;

   assign cur_a   = (mv_axis_ff == 2'd3) ? 2'd0 : mv_axis_ff;
   assign in_move = ph_ff == PH_PICK || ph_ff == PH_DROP;
   assign ld_a    = (in_move && cur_a != 2'd2) ? cur_a + 2'd1 : 2'd0;
   assign ld_drop = ph_ff == PH_DROP || (in_move && cur_a == 2'd2);
   assign home_a  = (ph_ff == PH_HOME_Y) ? 2'd1 : (ph_ff == PH_HOME_Z) ? 2'd2 : 2'd0;

   // distance of the axis now moving, and of the one loaded next
   always_comb begin
      if (ph_ff == PH_DROP) cur_d = (POS_WIDTH+1)'(drop_ff[cur_a]) - (POS_WIDTH+1)'(pick_ff[cur_a]);
      else                  cur_d = (POS_WIDTH+1)'(pick_ff[cur_a]) - (POS_WIDTH+1)'(pos[cur_a]);
      if (ld_drop) ld_d = (POS_WIDTH+1)'(drop_ff[ld_a]) - (POS_WIDTH+1)'(pick_ff[ld_a]);
      else         ld_d = (POS_WIDTH+1)'(pick_ff[ld_a]) - (POS_WIDTH+1)'(pos[ld_a]);
      rem_load = steps_of(ld_d);
   end

   always_comb begin
      ph_in      = ph_ff;
      mv_axis_in = mv_axis_ff;
      rem_in     = rem_ff;
      teach_in   = teach_ff;
      pt_in      = pt_inc;
      et_in      = et_ff;
      lv_in      = {estl, entl, endl};
      for (int a = 0; a < 3; a++) begin
         pick_in[a] = pick_ff[a];
         drop_in[a] = drop_ff[a];
         cmd[a]     = '{clear: 1'b0, stop: 1'b0, zero: 1'b0, start: 1'b0, dir: DIR_FWD};
      end

      if (est_fall) begin
         ph_in      = PH_ESTOP;
         mv_axis_in = 2'd0;
         rem_in     = '0;
         teach_in   = 2'd0;
         pt_in      = '0;
         et_in      = '0;
         for (int a = 0; a < 3; a++) begin
            pick_in[a]   = '0;
            drop_in[a]   = '0;
            cmd[a].clear = 1'b1;
         end
      end else begin
         case (ph_ff)
            PH_ESTOP: begin
               et_in = et_inc;
               if (est_rise && et_inc > edb_ff) begin
                  ph_in = PH_HOME_X;
                  et_in = '0;
               end
            end
            PH_HOME_X, PH_HOME_Y, PH_HOME_Z: begin
               if (end_fall && (ph_ff == PH_HOME_X || pt_inc > pdb_ff)) begin
                  cmd[home_a].stop = 1'b1;
                  pt_in = '0;
                  case (ph_ff)
                     PH_HOME_X: ph_in = PH_HOME_Y;
                     PH_HOME_Y: ph_in = PH_HOME_Z;
                     default: begin
                        ph_in = PH_JOG;
                        for (int a = 0; a < 3; a++) cmd[a].zero = 1'b1;
                     end
                  endcase
               end else begin
                  cmd[home_a].start = 1'b1;
               end
            end
            PH_JOG: begin
               if (!entl && all_idle && pt_inc > pdb_ff) begin
                  pt_in = '0;
                  if (teach_ff == 2'd0) begin
                     for (int a = 0; a < 3; a++) pick_in[a] = pos[a];
                     teach_in = 2'd1;
                  end else if (teach_ff == 2'd1) begin
                     for (int a = 0; a < 3; a++) drop_in[a] = pos[a];
                     teach_in = 2'd2;
                  end else begin
                     ph_in      = PH_PICK;
                     mv_axis_in = 2'd0;
                     rem_in     = rem_load;
                  end
               end
               if (ph_in == PH_JOG) begin
                  // forward wins when both directions are asked for
                  if (jx > xch_ff) cmd[0].start = 1'b1;
                  else if (jx < xcl_ff) begin
                     cmd[0].start = 1'b1;
                     cmd[0].dir   = DIR_REV;
                  end
                  if (jy > ych_ff) cmd[1].start = 1'b1;
                  else if (jy < ycl_ff) begin
                     cmd[1].start = 1'b1;
                     cmd[1].dir   = DIR_REV;
                  end
                  if (zp) cmd[2].start = 1'b1;
                  else if (zm) begin
                     cmd[2].start = 1'b1;
                     cmd[2].dir   = DIR_REV;
                  end
               end
            end
            PH_PICK, PH_DROP: begin
               if (busy[cur_a] == DIR_IDLE) begin
                  if (rem_ff != 16'd0) begin
                     cmd[cur_a].start = 1'b1;
                     cmd[cur_a].dir   = cur_d[POS_WIDTH] ? DIR_REV : DIR_FWD;
                     rem_in           = rem_ff - 16'd1;
                  end else if (cur_a != 2'd2) begin
                     mv_axis_in = ld_a;
                     rem_in     = rem_load;
                  end else if (ph_ff == PH_PICK) begin
                     ph_in      = PH_DROP;
                     mv_axis_in = 2'd0;
                     rem_in     = rem_load;
                  end else begin
                     ph_in = PH_DONE;
                  end
               end
            end
            default: ;
         endcase
      end

      rsp_data_in = {7'd0,
                     OUT_POS_W'(pos_nx[2]), OUT_POS_W'(pos_nx[1]), OUT_POS_W'(pos_nx[0]),
                     teach_in, phase_code(ph_in), coils[2], coils[1], coils[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff      <= PH_HOME_X;
         mv_axis_ff <= 2'd0;
         rem_ff     <= '0;
         teach_ff   <= 2'd0;
         pt_ff      <= '0;
         et_ff      <= '0;
         lv_ff      <= 3'b111;
         for (int a = 0; a < 3; a++) begin
            pick_ff[a] <= '0;
            drop_ff[a] <= '0;
         end
      end else if (adv) begin
         ph_ff      <= ph_in;
         mv_axis_ff <= mv_axis_in;
         rem_ff     <= rem_in;
         teach_ff   <= teach_in;
         pt_ff      <= pt_in;
         et_ff      <= et_in;
         lv_ff      <= lv_in;
         for (int a = 0; a < 3; a++) begin
            pick_ff[a] <= pick_in[a];
            drop_ff[a] <= drop_in[a];
         end
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_axis
      gjts_axis #(.PHASES(PHASES), .POS_WIDTH(POS_WIDTH)) u_axis (
         .clock         (clock),
         .reset         (reset),
         .enable        (adv),
         .cmd           (cmd[g]),
         .step_period   (step_period_ff),
         .busy          (busy[g]),
         .position      (pos[g]),
         .position_next (pos_nx[g]),
         .coils         (coils[g])
      );
   end

   a_stop_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff[14:12] == 3'd0 || rsp_data_ff[14:12] == 3'd7)
      |-> rsp_data_ff[11:0] == 12'd0) else $error("coils driven in emergency or done");
   a_teach: assert property (@(posedge clock) disable iff (reset)
      teach_ff != 2'd3) else $error("teach stage out of range");
   a_axis_sel: assert property (@(posedge clock) disable iff (reset)
      mv_axis_ff != 2'd3) else $error("move axis out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !adv |=> s1_valid_ff && $stable(s1_data_ff))
      else $error("held item lost");

endmodule

FILE: tb/gantry_home_jog_teach_sequencer_test.sv
// testbench for the gantry home, jog and teach sequencer: directed and random ticks
module gantry_home_jog_teach_sequencer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import gjts_pkg::*;

   localparam int IDLE_LIMIT = 3000;

   typedef enum logic [2:0] {
      RUN_ESTOP, RUN_HOME_X, RUN_HOME_Y, RUN_HOME_Z,
      RUN_JOG, RUN_PICK, RUN_DROP, RUN_DONE
   } run_type;

   typedef struct packed {
      logic [15:0] jx;
      logic [15:0] jy;
      logic        zp;
      logic        zm;
      logic        endl;
      logic        entl;
      logic        estl;
   } tick_type;

   typedef struct packed {
      logic [3:0]         cx;
      logic [3:0]         cy;
      logic [3:0]         cz;
      logic [2:0]         phase;
      logic [1:0]         taught;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] pz;
   } motion_type;

   logic clock, reset;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic req_tvalid, req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tvalid, rsp_tready;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   gantry_home_jog_teach_sequencer u_top (.*);

   // register copies
   logic [7:0]  step_period;
   logic [15:0] x_lo, x_hi, y_lo, y_hi;
   logic [9:0]  press_dbc;
   logic [7:0]  estop_dbc;

   // sequencer copy
   run_type     phase;
   int          pos[3], pickup[3], drop_pt[3];
   int          coil_idx[3];
   logic [7:0]  coil_tmr[3];
   dir_type     busy[3];
   int          mv_axis;
   logic [15:0] mv_left;
   logic [1:0]  taught;
   logic [9:0]  press_tmr;
   logic [7:0]  estop_tmr;
   logic [2:0]  last_lv;

   motion_type motion_q[$];
   int errors = 0, items_sent = 0, results_seen = 0, burst_left = 0;
   int idle_cycles = 0;
   bit random_on = 0;

   function automatic void halt_axis(int a);
      busy[a] = DIR_IDLE; coil_idx[a] = 0; coil_tmr[a] = '0;
   endfunction

   function automatic void begin_step(int a, dir_type d);
      if (busy[a] != DIR_IDLE) return;
      busy[a] = d; coil_idx[a] = 0; coil_tmr[a] = '0;
   endfunction

   function automatic int leg_delta(int a);
      if (phase == RUN_PICK) return pickup[a] - pos[a];
      return drop_pt[a] - pickup[a];
   endfunction

   function automatic void load_leg();
      int d;
      d = leg_delta(mv_axis);
      if (d < 0) d = -d;
      mv_left = 16'(d / int'(STEP_COUNTS));
   endfunction

   function automatic void wipe_motion();
      for (int a = 0; a < 3; a++) begin
         pos[a] = 0; pickup[a] = 0; drop_pt[a] = 0; halt_axis(a);
      end
      mv_axis = 0; mv_left = '0; taught = '0; press_tmr = '0; estop_tmr = '0;
   endfunction

   function automatic motion_type advance_tick(tick_type t);
      motion_type r;
      logic end_fall, est_fall, est_rise, quiet, fwd;
      int a, k;
      logic [3:0] coils[3];
      end_fall = last_lv[0] && !t.endl;
      est_fall = last_lv[2] && !t.estl;
      est_rise = !last_lv[2] && t.estl;
      last_lv = {t.estl, t.entl, t.endl};
      if (press_tmr < PRESS_TIMER_MAX) press_tmr++;
      if (est_fall) begin
         wipe_motion();
         phase = RUN_ESTOP;
      end else if (phase == RUN_ESTOP) begin
         if (estop_tmr < ESTOP_TIMER_MAX) estop_tmr++;
         if (est_rise && estop_tmr > estop_dbc) begin
            phase = RUN_HOME_X; estop_tmr = '0;
         end
      end else if (phase inside {RUN_HOME_X, RUN_HOME_Y, RUN_HOME_Z}) begin
         a = int'(phase) - 1;
         if (end_fall && (phase == RUN_HOME_X || press_tmr > press_dbc)) begin
            halt_axis(a);
            press_tmr = '0;
            phase = run_type'(phase + 1);
            if (phase == RUN_JOG) for (int i = 0; i < 3; i++) pos[i] = 0;
         end else begin
            begin_step(a, DIR_FWD);
         end
      end else if (phase == RUN_JOG) begin
         quiet = busy[0] == DIR_IDLE && busy[1] == DIR_IDLE && busy[2] == DIR_IDLE;
         if (!t.entl && quiet && press_tmr > press_dbc) begin
            press_tmr = '0;
            if (taught == 0) begin
               for (int i = 0; i < 3; i++) pickup[i] = pos[i];
               taught = 1;
            end else if (taught == 1) begin
               for (int i = 0; i < 3; i++) drop_pt[i] = pos[i];
               taught = 2;
            end else begin
               phase = RUN_PICK; mv_axis = 0; load_leg();
            end
         end
         if (phase == RUN_JOG) begin
            if (t.jx > x_hi) begin_step(0, DIR_FWD);
            else if (t.jx < x_lo) begin_step(0, DIR_REV);
            if (t.jy > y_hi) begin_step(1, DIR_FWD);
            else if (t.jy < y_lo) begin_step(1, DIR_REV);
            if (t.zp) begin_step(2, DIR_FWD);
            else if (t.zm) begin_step(2, DIR_REV);
         end
      end else if (phase == RUN_PICK || phase == RUN_DROP) begin
         a = mv_axis;
         if (busy[a] == DIR_IDLE) begin
            if (mv_left > 0) begin
               begin_step(a, leg_delta(a) < 0 ? DIR_REV : DIR_FWD);
               mv_left--;
            end else if (a < 2) begin
               mv_axis = a + 1; load_leg();
            end else if (phase == RUN_PICK) begin
               phase = RUN_DROP; mv_axis = 0; load_leg();
            end else begin
               phase = RUN_DONE;
            end
         end
      end
      for (a = 0; a < 3; a++) begin
         coils[a] = '0;
         if (busy[a] != DIR_IDLE) begin
            k = coil_idx[a] & 3;
            fwd = busy[a] == DIR_FWD;
            coils[a] = fwd ? 4'b0001 << k : 4'b1000 >> k;
            coil_tmr[a]++;
            if (coil_tmr[a] >= step_period) begin
               coil_tmr[a] = '0;
               coil_idx[a]++;
               if (coil_idx[a] >= 4) begin
                  halt_axis(a);
                  pos[a] += fwd ? int'(STEP_COUNTS) : -int'(STEP_COUNTS);
                  if (pos[a] > 32767) pos[a] = 32767;
                  if (pos[a] < -32768) pos[a] = -32768;
               end
            end
         end
      end
      r.cx = coils[0]; r.cy = coils[1]; r.cz = coils[2];
      r.phase = phase; r.taught = taught;
      r.px = pos[0][15:0]; r.py = pos[1][15:0]; r.pz = pos[2][15:0];
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // sender: bursts with random gaps
   task automatic send_tick(tick_type t);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_tdata <= {3'b000, t.estl, t.entl, t.endl, t.zm, t.zp, t.jy, t.jx};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      motion_q.push_back(advance_tick(t));
      burst_left--;
      items_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      wait (motion_q.size() == 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_W'(idx) << 2; csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         REG_STEP_PERIOD:    step_period = val[7:0];
         REG_X_CENTRE_LOW:   x_lo = val[15:0];
         REG_X_CENTRE_HIGH:  x_hi = val[15:0];
         REG_Y_CENTRE_LOW:   y_lo = val[15:0];
         REG_Y_CENTRE_HIGH:  y_hi = val[15:0];
         REG_PRESS_DEBOUNCE: press_dbc = val[9:0];
         REG_ESTOP_DEBOUNCE: estop_dbc = val[7:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(int sp, int xl, int xh, int yl, int yh, int pd, int ed);
      settle();
      write_reg(REG_STEP_PERIOD, sp);
      write_reg(REG_X_CENTRE_LOW, xl);
      write_reg(REG_X_CENTRE_HIGH, xh);
      write_reg(REG_Y_CENTRE_LOW, yl);
      write_reg(REG_Y_CENTRE_HIGH, yh);
      write_reg(REG_PRESS_DEBOUNCE, pd);
      write_reg(REG_ESTOP_DEBOUNCE, ed);
   endtask

   // joystick in the centre band where one exists, buttons released
   function automatic tick_type calm_tick();
      tick_type t;
      t.jx = (x_lo <= x_hi) ? 16'((32'(x_lo) + 32'(x_hi)) / 2) : x_lo;
      t.jy = (y_lo <= y_hi) ? 16'((32'(y_lo) + 32'(y_hi)) / 2) : y_lo;
      t.zp = 0; t.zm = 0; t.endl = 1; t.entl = 1; t.estl = 1;
      return t;
   endfunction

   function automatic tick_type jog_tick();
      tick_type t;
      t = calm_tick();
      case ($urandom_range(0, 4))
         0: t.jx = 16'($urandom);
         1: t.jx = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: ;
      endcase
      case ($urandom_range(0, 4))
         0: t.jy = 16'($urandom);
         1: t.jy = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: ;
      endcase
      t.zp = $urandom_range(0, 3) == 0;
      t.zm = $urandom_range(0, 3) == 0;
      t.endl = 1'($urandom_range(0, 1));
      return t;
   endfunction

   task automatic send_calm(int n);
      repeat (n) send_tick(calm_tick());
   endtask

   // emergency fall, optional early rise, then accepted release
   task automatic cycle_estop(bit early);
      tick_type t;
      t = calm_tick(); t.estl = 0;
      send_tick(t);
      if (early && estop_dbc > 1) begin
         send_tick(calm_tick());
         send_tick(t);
      end
      repeat (int'(estop_dbc) + $urandom_range(1, 3)) send_tick(t);
      send_tick(calm_tick());
   endtask

   task automatic run_homing();
      tick_type t;
      for (int n = 0; n < 400 && phase inside {RUN_HOME_X, RUN_HOME_Y, RUN_HOME_Z}; n++) begin
         t = calm_tick();
         t.jx = 16'($urandom);
         t.endl = $urandom_range(0, 2) != 0;
         send_tick(t);
      end
   endtask

   task automatic press_enter();
      tick_type t;
      logic [1:0] was;
      run_type ph0;
      was = taught; ph0 = phase;
      t = calm_tick(); t.entl = 0;
      for (int n = 0; n < 80 && taught == was && phase == ph0; n++) send_tick(t);
      send_tick(calm_tick());
   endtask

   task automatic finish_move();
      for (int n = 0; n < 6000 && (phase == RUN_PICK || phase == RUN_DROP); n++)
         send_tick(calm_tick());
   endtask

   task automatic test_homing_and_jog();
      tick_type t;
      set_regs(1, 31000, 33500, 31000, 34500, 2, 2);
      // x endstop needs no debounce, y and z do
      send_calm(2);
      t = calm_tick(); t.endl = 0; send_tick(t);
      send_tick(calm_tick()); send_tick(t);
      send_calm(3); send_tick(t);
      send_calm(3); send_tick(t);
      // joystick extremes, both z buttons together
      t = calm_tick(); t.jx = 16'hFFFF; t.jy = 16'h0000; t.zp = 1; t.zm = 1;
      send_tick(t);
      t.jx = 16'h0000; t.jy = 16'hFFFF; t.zp = 0;
      send_tick(t);
      // enter held while axes still stepping
      t = calm_tick(); t.entl = 0; repeat (3) send_tick(t);
      // emergency stop with an early rise, then an accepted release
      send_calm(1);
      cycle_estop(1);
   endtask

   task automatic test_register_extremes();
      tick_type t;
      set_regs(0, 0, 65535, 65535, 0, 0, 0);
      cycle_estop(0);
      run_homing();
      repeat (20) send_tick(jog_tick());
      press_enter(); press_enter(); press_enter();
      finish_move();
      send_calm(2);
      // never accepted debounces and the slowest step
      set_regs(255, 100, 200, 65535, 65535, 1023, 255);
      t = calm_tick(); t.estl = 0; send_tick(t);
      repeat (6) send_tick(t);
      send_calm(2);
      t = calm_tick(); t.estl = 0; send_tick(t);
      send_calm(1);
      set_regs(255, 100, 200, 65535, 65535, 1023, 3);
      cycle_estop(0);
      run_homing();
      repeat (12) send_tick(jog_tick());
      t = calm_tick(); t.entl = 0; repeat (8) send_tick(t);
      send_calm(4);
   endtask

   task automatic test_random_sessions();
      int lo, hi;
      bit cut;
      random_on = 1;
      while (items_sent < 460) begin
         lo = $urandom_range(20000, 32000); hi = $urandom_range(lo, 40000);
         set_regs($urandom_range(1, 3), lo, hi, $urandom_range(20000, 32000),
                  $urandom_range(32000, 45000), $urandom_range(0, 6),
                  $urandom_range(0, 5));
         cut = $urandom_range(0, 4) == 0;
         cycle_estop(1'($urandom_range(0, 1)));
         run_homing();
         if (cut) continue;
         for (int s = 0; s < 3; s++) begin
            repeat ($urandom_range(4, 25)) send_tick(jog_tick());
            send_calm(8);
            press_enter();
         end
         if ($urandom_range(0, 5) == 0) continue;
         finish_move();
         send_calm($urandom_range(1, 4));
      end
   endtask

   // receiver stalls with a changing pattern, plus one long hold-off
   initial begin
      int cyc, mode, hold;
      cyc = 0; mode = 0; hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc % 64 == 0) mode = $urandom_range(0, 2);
         if (random_on && hold == 0 && cyc > 0) begin
            hold = 300;
            random_on = 0;
         end
         if (hold > 1) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (mode == 0) rsp_tready <= 1'b1;
         else if (mode == 1) rsp_tready <= 1'($urandom_range(0, 1));
         else rsp_tready <= $urandom_range(0, 7) != 0;
      end
   end

   always @(posedge clock) begin
      motion_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[3:0], rsp_tdata[7:4], rsp_tdata[11:8], rsp_tdata[14:12],
                rsp_tdata[16:15], rsp_tdata[32:17], rsp_tdata[48:33], rsp_tdata[64:49]};
         results_seen++;
         if (motion_q.size() == 0) begin
            $error("result with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            want = motion_q.pop_front();
            if (got.cx !== want.cx) begin
               $error("coils_x exp %h got %h", want.cx, got.cx); errors++;
            end
            if (got.cy !== want.cy) begin
               $error("coils_y exp %h got %h", want.cy, got.cy); errors++;
            end
            if (got.cz !== want.cz) begin
               $error("coils_z exp %h got %h", want.cz, got.cz); errors++;
            end
            if (got.phase !== want.phase) begin
               $error("phase_of_run exp %0d got %0d", want.phase, got.phase); errors++;
            end
            if (got.taught !== want.taught) begin
               $error("teach_stage exp %0d got %0d", want.taught, got.taught); errors++;
            end
            if (got.px !== want.px) begin
               $error("position_x exp %0d got %0d", want.px, got.px); errors++;
            end
            if (got.py !== want.py) begin
               $error("position_y exp %0d got %0d", want.py, got.py); errors++;
            end
            if (got.pz !== want.pz) begin
               $error("position_z exp %0d got %0d", want.pz, got.pz); errors++;
            end
         end
      end
   end

   // watchdog on cycles with no item moving on any port
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      step_period = 8'd3; x_lo = 16'd31000; x_hi = 16'd33500;
      y_lo = 16'd31000; y_hi = 16'd34500; press_dbc = 10'd250; estop_dbc = 8'd15;
      wipe_motion();
      phase = RUN_HOME_X; last_lv = 3'b111;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_homing_and_jog();
      test_register_extremes();
      test_random_sessions();
      req_tvalid <= 1'b0;
      wait (motion_q.size() == 0);
      repeat (10) @(posedge clock);
      $display("ticks sent %0d, results checked %0d: homing, jog, teach, automatic moves,",
               items_sent, results_seen);
      $display("emergency stop and release, register extremes, stalls on both sides");
      if (errors == 0 && motion_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: sim.f
design/gjts_pkg.sv
design/gjts_axis.sv
design/gantry_home_jog_teach_sequencer.sv
tb/gantry_home_jog_teach_sequencer_test.sv
